// File: hdl/gaussian_blur_rgb_window_macros.svh
// Assertion macros for the blur block checker
`ifndef GAUSSIAN_BLUR_RGB_WINDOW_MACROS_SVH
`define GAUSSIAN_BLUR_RGB_WINDOW_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define GB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/gbrw_pkg.sv
`timescale 1ns / 1ps
package gbrw_pkg;
    localparam int MAX_RADIUS = 3;
    localparam int MAX_WIDTH  = 1024;
    localparam int SIDE_MAX   = 2 * MAX_RADIUS + 1;
    localparam int NWEIGHTS   = SIDE_MAX * SIDE_MAX;
    localparam int NLINES     = 2 * MAX_RADIUS;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int LINE_W     = $clog2(NLINES);
    localparam int SIDE_W     = $clog2(SIDE_MAX + 1);
    localparam int WIDX_W     = $clog2(NWEIGHTS);
    localparam int ACC_W      = 30;

    localparam logic ACT_WEIGHT = 1'b0;
    localparam logic ACT_PIXEL  = 1'b1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_DRAIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear;
        logic enable;
    } mac_ctrl_t;
endpackage

// File: hdl/gaussian_blur_rgb_window.sv
`timescale 1ns / 1ps
// Gaussian blur over a raster BGR pixel stream with a host-loaded Q0.16
// kernel of side 2R+1 (R up to 3). An accepted pixel takes one line store
// read per stored row, then the store write and, when it completes an
// interior window, the shared multiply-accumulate, one tap per cycle; then
// the result is held until taken. The block is not ready while a pixel is
// in work. Any write to the width, height or radius register restarts the
// frame. Border pixels give no result. Line store and kernel contents are
// undefined until written.
module gaussian_blur_rgb_window
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [5:0]  weight_index,
    input  logic [15:0] weight_value,
    input  logic [7:0]  in_blue,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_red,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_green,
    output logic [7:0]  out_red,
    output logic [7:0]  out_alpha,
    output logic [11:0] center_row,
    output logic [9:0]  center_col
);
    localparam int SM  = gbrw_pkg::SIDE_MAX;
    localparam int CW  = gbrw_pkg::COL_W;
    localparam int LW  = gbrw_pkg::LINE_W;
    localparam int SW  = gbrw_pkg::SIDE_W;
    localparam int WW  = gbrw_pkg::WIDX_W;
    localparam int MEM_DEPTH = gbrw_pkg::NLINES * gbrw_pkg::MAX_WIDTH;
    localparam int MA_W = $clog2(MEM_DEPTH);

    gbrw_pkg::state_t state_reg, state_next;

    logic [10:0] width_reg;
    logic [11:0] height_reg;
    logic [1:0]  radius_reg;
    logic [11:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [LW-1:0] row_slot_reg;

    logic [23:0] win_reg [SM][SM];
    logic [23:0] pix_reg;
    logic [15:0] kern_mem [gbrw_pkg::NWEIGHTS];
    logic [23:0] line_mem [MEM_DEPTH];

    logic [SW-1:0] k_reg, l_reg;
    logic [WW-1:0] widx_reg;
    logic          rd_pend_reg;
    logic [SW-1:0] rd_k_reg;
    logic [23:0]   line_q_reg;
    logic [15:0]   kern_q_reg;
    logic [23:0]   tap_q_reg;
    logic [LW-1:0] slot_reg;

    logic [7:0] res_b_reg, res_g_reg, res_r_reg;
    logic [11:0] res_row_reg;
    logic [9:0]  res_col_reg;
    logic        out_valid_reg;

    logic [1:0]  rad;
    logic [SW-1:0] side, nl;
    logic [10:0] weff;
    logic [11:0] heff;
    logic        interior;
    logic        last_load, last_tap;
    logic        in_acc, cfg_acc;
    gbrw_pkg::mac_ctrl_t mac_ctrl;
    logic [7:0]  sat_b, sat_g, sat_r;

    assign rad  = radius_reg;
    assign side = SW'({rad, 1'b1});
    assign nl   = SW'({rad, 1'b0});
    assign weff = (width_reg == 11'd0) ? 11'd1 :
                  (width_reg > 11'(gbrw_pkg::MAX_WIDTH)) ? 11'(gbrw_pkg::MAX_WIDTH) : width_reg;
    assign heff = (height_reg == 12'd0) ? 12'd1 : height_reg;
    assign interior = (row_reg >= 12'(nl)) && (11'(col_reg) >= 11'(nl));

    assign in_ready  = (state_reg == gbrw_pkg::ST_IDLE) && !out_valid_reg;
    assign cfg_ready = (state_reg == gbrw_pkg::ST_IDLE) && !out_valid_reg;
    assign in_acc    = in_valid && in_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign last_load = (k_reg == nl);
    assign last_tap  = (k_reg == side - SW'(1)) && (l_reg == side - SW'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gbrw_pkg::ST_IDLE:
                if (in_acc && action == gbrw_pkg::ACT_PIXEL)
                    state_next = gbrw_pkg::ST_LOAD;
            gbrw_pkg::ST_LOAD:
                if (last_load)
                    state_next = interior ? gbrw_pkg::ST_MAC : gbrw_pkg::ST_IDLE;
            gbrw_pkg::ST_MAC:
                if (last_tap)
                    state_next = gbrw_pkg::ST_DRAIN;
            gbrw_pkg::ST_DRAIN:
                if (!rd_pend_reg)
                    state_next = gbrw_pkg::ST_OUT;
            gbrw_pkg::ST_OUT:
                state_next = gbrw_pkg::ST_IDLE;
            default:
                state_next = gbrw_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        mac_ctrl.clear  = 1'b0;
        mac_ctrl.enable = 1'b0;
        case (state_reg)
            gbrw_pkg::ST_LOAD:  mac_ctrl.clear  = 1'b1;
            gbrw_pkg::ST_MAC,
            gbrw_pkg::ST_DRAIN: mac_ctrl.enable = rd_pend_reg;
            default:            mac_ctrl.clear  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gbrw_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration and position; row_slot tracks row modulo 2R
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= 11'd640;
            height_reg   <= 12'd480;
            radius_reg   <= 2'd1;
            row_reg      <= '0;
            col_reg      <= '0;
            row_slot_reg <= '0;
        end
        else if (cfg_acc)
        begin
            case (cfg_index)
                gbrw_pkg::REG_WIDTH:  width_reg  <= cfg_data[10:0];
                gbrw_pkg::REG_HEIGHT: height_reg <= cfg_data;
                gbrw_pkg::REG_RADIUS: radius_reg <= cfg_data[1:0];
                default:              width_reg  <= width_reg;
            endcase
            if (cfg_index inside {gbrw_pkg::REG_WIDTH, gbrw_pkg::REG_HEIGHT,
                                  gbrw_pkg::REG_RADIUS})
            begin
                row_reg      <= '0;
                col_reg      <= '0;
                row_slot_reg <= '0;
            end
        end
        else if (state_reg == gbrw_pkg::ST_LOAD && last_load)
        begin
            if (11'(col_reg) + 11'd1 >= weff)
            begin
                col_reg <= '0;
                if (row_reg + 12'd1 >= heff)
                begin
                    row_reg      <= 12'd0;
                    row_slot_reg <= '0;
                end
                else
                begin
                    row_reg      <= row_reg + 12'd1;
                    row_slot_reg <= (row_slot_reg + LW'(1) >= LW'(nl)) ? '0
                                                                       : row_slot_reg + LW'(1);
                end
            end
            else
                col_reg <= col_reg + CW'(1);
        end
    end

    // kernel store
    always_ff @(posedge clk)
    begin
        if (in_acc && action == gbrw_pkg::ACT_WEIGHT &&
            weight_index < 6'(gbrw_pkg::NWEIGHTS))
            kern_mem[weight_index[WW-1:0]] <= weight_value;
        kern_q_reg <= kern_mem[widx_reg];
    end

    // line store: one read or write per cycle
    logic          ls_we;
    logic [MA_W-1:0] ls_addr;
    logic [LW-1:0] rd_slot;
    logic [SW:0]   slot_sum;

    assign slot_sum = (SW+1)'(slot_reg) + (SW+1)'(k_reg);
    assign rd_slot  = (slot_sum >= (SW+1)'(nl)) ? LW'(slot_sum - (SW+1)'(nl))
                                                : LW'(slot_sum);
    assign ls_we    = (state_reg == gbrw_pkg::ST_LOAD) && last_load && (rad != 2'd0);
    assign ls_addr  = ls_we ? {slot_reg, col_reg} : {rd_slot, col_reg};

    always_ff @(posedge clk)
    begin
        if (ls_we)
            line_mem[ls_addr] <= pix_reg;
        line_q_reg <= line_mem[ls_addr];
    end

    // sequencer counters and window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg        <= '0;
            l_reg        <= '0;
            widx_reg     <= '0;
            rd_pend_reg  <= 1'b0;
            rd_k_reg     <= '0;
            slot_reg     <= '0;
            pix_reg      <= '0;
            tap_q_reg    <= '0;
            for (int i = 0; i < SM; i++)
                for (int j = 0; j < SM; j++)
                    win_reg[i][j] <= '0;
        end
        else
        begin
            rd_pend_reg  <= 1'b0;
            case (state_reg)
                gbrw_pkg::ST_IDLE:
                begin
                    k_reg <= '0;
                    l_reg <= '0;
                    widx_reg <= '0;
                    if (in_acc && action == gbrw_pkg::ACT_PIXEL)
                    begin
                        pix_reg  <= {in_red, in_green, in_blue};
                        slot_reg <= row_slot_reg;
                        // shift window left by one column
                        for (int i = 0; i < SM; i++)
                            for (int j = 0; j < SM - 1; j++)
                                if (j + 1 < int'(side))
                                    win_reg[i][j] <= win_reg[i][j+1];
                    end
                end
                gbrw_pkg::ST_LOAD:
                begin
                    // read row k; the registered read data goes into the right column in the next cycle
                    if (!last_load)
                    begin
                        rd_pend_reg <= 1'b1;
                        rd_k_reg    <= k_reg;
                        k_reg       <= k_reg + SW'(1);
                    end
                    else
                    begin
                        win_reg[nl][nl] <= pix_reg;
                        k_reg <= '0;
                    end
                    if (rd_pend_reg)
                        win_reg[rd_k_reg][nl] <= line_q_reg;
                end
                gbrw_pkg::ST_MAC:
                begin
                    // tap and weight registered together; accumulated next cycle
                    rd_pend_reg <= 1'b1;
                    tap_q_reg   <= win_reg[k_reg][l_reg];
                    widx_reg    <= widx_reg + WW'(1);
                    if (l_reg == side - SW'(1))
                    begin
                        l_reg <= '0;
                        k_reg <= k_reg + SW'(1);
                    end
                    else
                        l_reg <= l_reg + SW'(1);
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    gbrw_mac u_mac
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .weight    (kern_q_reg),
        .pixel     (tap_q_reg),
        .sat_blue  (sat_b),
        .sat_green (sat_g),
        .sat_red   (sat_r)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == gbrw_pkg::ST_OUT)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == gbrw_pkg::ST_LOAD && last_load)
        begin
            res_row_reg <= row_reg - 12'(rad);
            res_col_reg <= 10'(col_reg - CW'(rad));
        end
        if (state_reg == gbrw_pkg::ST_OUT)
        begin
            res_b_reg <= sat_b;
            res_g_reg <= sat_g;
            res_r_reg <= sat_r;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_blue   = res_b_reg;
    assign out_green  = res_g_reg;
    assign out_red    = res_r_reg;
    assign out_alpha  = 8'hFF;
    assign center_row = res_row_reg;
    assign center_col = res_col_reg;
endmodule

// File: hdl/gbrw_mac.sv
`timescale 1ns / 1ps
// Shared multiply-accumulate: one tap per cycle while enabled, for all three channels.
module gbrw_mac
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  gbrw_pkg::mac_ctrl_t      ctrl,
    input  logic [15:0]              weight,
    input  logic [23:0]              pixel,
    output logic [7:0]               sat_blue,
    output logic [7:0]               sat_green,
    output logic [7:0]               sat_red
);
    logic [gbrw_pkg::ACC_W-1:0] acc_b_reg, acc_g_reg, acc_r_reg;
    logic [23:0] prod_b, prod_g, prod_r;

    assign prod_b = weight * pixel[7:0];
    assign prod_g = weight * pixel[15:8];
    assign prod_r = weight * pixel[23:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_b_reg <= '0;
            acc_g_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            acc_b_reg <= '0;
            acc_g_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (ctrl.enable)
        begin
            acc_b_reg <= acc_b_reg + gbrw_pkg::ACC_W'(prod_b);
            acc_g_reg <= acc_g_reg + gbrw_pkg::ACC_W'(prod_g);
            acc_r_reg <= acc_r_reg + gbrw_pkg::ACC_W'(prod_r);
        end
    end

    // truncate Q0.16 then clamp
    always_comb
    begin
        sat_blue  = (|acc_b_reg[gbrw_pkg::ACC_W-1:24]) ? 8'hFF : acc_b_reg[23:16];
        sat_green = (|acc_g_reg[gbrw_pkg::ACC_W-1:24]) ? 8'hFF : acc_g_reg[23:16];
        sat_red   = (|acc_r_reg[gbrw_pkg::ACC_W-1:24]) ? 8'hFF : acc_r_reg[23:16];
    end
endmodule

// File: hdl/gbrw_checker.sv
`timescale 1ns / 1ps
`include "gaussian_blur_rgb_window_macros.svh"
module gbrw_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       action,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_alpha,
    input logic [7:0] out_blue
);
    `GB_ASSERT_IMP(a_alpha, out_valid, out_alpha == 8'hFF, "alpha not 255")
    `GB_ASSERT_NEXT(a_busy, in_valid && in_ready && action, !in_ready, "ready after pixel")
    `GB_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_blue),
        "result dropped")
    `GB_ASSERT_IMP(a_noaccept, out_valid, !in_ready, "input taken with result pending")
endmodule

bind gaussian_blur_rgb_window gbrw_checker u_gbrw_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_alpha (out_alpha),
    .out_blue  (out_blue)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 120;

    localparam int KMODE_CENTER = 0;
    localparam int KMODE_SPREAD = 1;
    localparam int KMODE_RANDOM = 2;
    localparam int KMODE_ONES   = 3;

    typedef struct {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  alpha;
        logic [11:0] row;
        logic [9:0]  col;
    } blur_pixel_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [5:0]  weight_index;
    logic [15:0] weight_value;
    logic [7:0]  in_blue;
    logic [7:0]  in_green;
    logic [7:0]  in_red;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_blue;
    logic [7:0]  out_green;
    logic [7:0]  out_red;
    logic [7:0]  out_alpha;
    logic [11:0] center_row;
    logic [9:0]  center_col;

    gaussian_blur_rgb_window dut (.*);

    // shadow copy of the block state
    logic [23:0] line_mem [gbrw_pkg::NLINES * gbrw_pkg::MAX_WIDTH];
    logic [15:0] kern [gbrw_pkg::NWEIGHTS];
    logic [23:0] win [gbrw_pkg::SIDE_MAX][gbrw_pkg::SIDE_MAX];
    int unsigned pos_row, pos_col;
    int unsigned reg_width, reg_height, reg_radius;

    blur_pixel_t blurred_q [$];
    int          fail_count;
    int          items_sent;
    bit          sender_burst;
    bit          receiver_burst;
    int          hold_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("** gaussian_blur_rgb_window: FAILED **");
        $finish;
    end

    function automatic logic [7:0] clip_channel(input int unsigned acc);
        int unsigned v;
        v = acc >> 16;
        return (v > 255) ? 8'hFF : v[7:0];
    endfunction

    task automatic blur_predict(input logic act, input logic [5:0] wi, input logic [15:0] wv,
                                input logic [7:0] b, input logic [7:0] g, input logic [7:0] rd);
        int unsigned r, side, w, h, rw, cl, nl, slot;
        int unsigned ab, ag, ar;
        logic [23:0] pix;
        blur_pixel_t e;
        r = reg_radius;
        side = 2 * r + 1;
        w = (reg_width == 0) ? 1 :
            ((reg_width > gbrw_pkg::MAX_WIDTH) ? gbrw_pkg::MAX_WIDTH : reg_width);
        h = (reg_height == 0) ? 1 : reg_height;
        if (act == gbrw_pkg::ACT_WEIGHT)
        begin
            if (wi < gbrw_pkg::NWEIGHTS)
                kern[wi] = wv;
            return;
        end
        pix = {rd, g, b};
        rw = pos_row;
        cl = pos_col;
        if (cl >= gbrw_pkg::MAX_WIDTH)
            cl = gbrw_pkg::MAX_WIDTH - 1;
        for (int k = 0; k < side; k++)
            for (int l = 0; l + 1 < side; l++)
                win[k][l] = win[k][l + 1];
        if (r > 0)
        begin
            nl = 2 * r;
            for (int k = 0; k < nl; k++)
            begin
                slot = (rw + k) % nl;
                win[k][side - 1] = line_mem[slot * gbrw_pkg::MAX_WIDTH + cl];
            end
            line_mem[(rw % nl) * gbrw_pkg::MAX_WIDTH + cl] = pix;
        end
        win[side - 1][side - 1] = pix;
        if (rw >= 2 * r && cl >= 2 * r)
        begin
            ab = 0;
            ag = 0;
            ar = 0;
            for (int k = 0; k < side; k++)
                for (int l = 0; l < side; l++)
                begin
                    ab += kern[k * side + l] * win[k][l][7:0];
                    ag += kern[k * side + l] * win[k][l][15:8];
                    ar += kern[k * side + l] * win[k][l][23:16];
                end
            e.blue  = clip_channel(ab);
            e.green = clip_channel(ag);
            e.red   = clip_channel(ar);
            e.alpha = 8'hFF;
            e.row   = 12'((rw - r) & 12'hFFF);
            e.col   = 10'((cl - r) & 10'h3FF);
            blurred_q.push_back(e);
        end
        cl++;
        if (cl >= w)
        begin
            cl = 0;
            rw++;
            if (rw >= h)
                rw = 0;
        end
        pos_col = cl & 10'h3FF;
        pos_row = rw & 12'hFFF;
    endtask

    task automatic send_item(input logic act, input logic [5:0] wi, input logic [15:0] wv,
                             input logic [7:0] b, input logic [7:0] g, input logic [7:0] rd);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action       <= act;
        weight_index <= wi;
        weight_value <= wv;
        in_blue      <= b;
        in_green     <= g;
        in_red       <= rd;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        blur_predict(act, wi, wv, b, g, rd);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] rd);
        send_item(gbrw_pkg::ACT_PIXEL, 6'($urandom), 16'($urandom), b, g, rd);
    endtask

    task automatic send_rand_pixel();
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_weight(input logic [5:0] wi, input logic [15:0] wv);
        send_item(gbrw_pkg::ACT_WEIGHT, wi, wv, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // wait until all results are in, then let any pixel still in work finish
    task automatic settle();
        in_valid <= 1'b0;
        while (blurred_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            gbrw_pkg::REG_WIDTH:  reg_width  = data & 12'h7FF;
            gbrw_pkg::REG_HEIGHT: reg_height = data;
            gbrw_pkg::REG_RADIUS: reg_radius = data & 12'h3;
            default:    ;
        endcase
        if (idx != REG_UNUSED)
        begin
            pos_row = 0;
            pos_col = 0;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned r);
        settle();
        write_reg(gbrw_pkg::REG_WIDTH, 12'(w));
        write_reg(gbrw_pkg::REG_HEIGHT, 12'(h));
        write_reg(gbrw_pkg::REG_RADIUS, 12'(r));
    endtask

    // center tap only, spread near evenly, fully random, or all ones
    task automatic load_kernel(input int mode, input int unsigned side);
        int unsigned share;
        share = 65536 / (side * side);
        for (int i = 0; i < gbrw_pkg::NWEIGHTS; i++)
        begin
            case (mode)
                KMODE_CENTER:
                    send_weight(6'(i), (i == (side * side) / 2) ? 16'hFFFF : 16'h0000);
                KMODE_SPREAD: send_weight(6'(i), 16'(share - $urandom_range(0, share / 4)));
                KMODE_RANDOM: send_weight(6'(i), 16'($urandom));
                default: send_weight(6'(i), 16'hFFFF);
            endcase
        end
    endtask

    // receiver: random stall per result, with optional long hold-off
    initial begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
            end
            else
                n = receiver_burst ? 0 : $urandom_range(0, 18);
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        blur_pixel_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (blurred_q.size() == 0)
            begin
                $error("result with nothing expected: row %0d col %0d", center_row, center_col);
                fail_count++;
            end
            else
            begin
                e = blurred_q.pop_front();
                if (out_blue !== e.blue)
                begin
                    $error("out_blue expected %0d got %0d", e.blue, out_blue);
                    fail_count++;
                end
                if (out_green !== e.green)
                begin
                    $error("out_green expected %0d got %0d", e.green, out_green);
                    fail_count++;
                end
                if (out_red !== e.red)
                begin
                    $error("out_red expected %0d got %0d", e.red, out_red);
                    fail_count++;
                end
                if (out_alpha !== e.alpha)
                begin
                    $error("out_alpha expected %0d got %0d", e.alpha, out_alpha);
                    fail_count++;
                end
                if (center_row !== e.row)
                begin
                    $error("center_row expected %0d got %0d", e.row, center_row);
                    fail_count++;
                end
                if (center_col !== e.col)
                begin
                    $error("center_col expected %0d got %0d", e.col, center_col);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed();
        // 5x5, radius 1, identity kernel, extreme pixels
        set_frame(5, 5, 1);
        load_kernel(KMODE_CENTER, 3);
        send_weight(6'h3F, 16'hFFFF);
        send_weight(6'd49, 16'h1234);
        for (int i = 0; i < 25; i++)
            if (i % 3 == 0)
                send_pixel(8'h00, 8'hFF, 8'h00);
            else if (i % 3 == 1)
                send_pixel(8'hFF, 8'h00, 8'hFF);
            else
                send_rand_pixel();
        // all-ones kernel saturates
        settle();
        load_kernel(KMODE_ONES, 3);
        for (int i = 0; i < 12; i++)
            send_pixel(8'hFF, 8'hFF, 8'hFF);
        // unused register index must not restart the frame
        settle();
        write_reg(REG_UNUSED, 12'hFFF);
        for (int i = 0; i < 13; i++)
            send_rand_pixel();
        // oversize width clamps, radius 0 makes every pixel interior
        set_frame(12'hFFF, 2, 0);
        load_kernel(KMODE_SPREAD, 1);
        for (int i = 0; i < 6; i++)
            send_rand_pixel();
        // zero width and zero height both act as one
        set_frame(0, 0, 0);
        for (int i = 0; i < 5; i++)
            send_rand_pixel();
        set_frame(3, 0, 0);
        for (int i = 0; i < 7; i++)
            send_rand_pixel();
        // radius 3: window just fits, then window wider than the image
        set_frame(7, 7, 3);
        load_kernel(KMODE_SPREAD, 7);
        for (int i = 0; i < 49; i++)
            send_rand_pixel();
        set_frame(6, 8, 3);
        for (int i = 0; i < 48; i++)
            send_rand_pixel();
    endtask

    task automatic test_random_frames();
        int unsigned w, h, r, n;
        while (items_sent < 850)
        begin
            r = $urandom_range(0, 3);
            if ($urandom_range(0, 9) < 8)
            begin
                w = $urandom_range(2 * r + 1, 2 * r + 12);
                h = $urandom_range(2 * r + 1, 2 * r + 6);
            end
            else
            begin
                w = $urandom_range(1, 20);
                h = $urandom_range(1, 10);
            end
            sender_burst   = ($urandom_range(0, 4) == 0);
            receiver_burst = ($urandom_range(0, 4) == 0);
            set_frame(w, h, r);
            load_kernel(($urandom_range(0, 2) == 0) ? KMODE_RANDOM : KMODE_SPREAD, 2 * r + 1);
            n = w * h + $urandom_range(0, w);
            if (n > 120)
                n = 120;
            for (int i = 0; i < n; i++)
                if ($urandom_range(0, 19) == 0)
                    send_weight(6'($urandom), 16'($urandom));
                else
                    send_rand_pixel();
        end
        sender_burst   = 1'b0;
        receiver_burst = 1'b0;
    endtask

    task automatic test_backpressure();
        set_frame(8, 6, 0);
        load_kernel(KMODE_RANDOM, 1);
        settle();
        hold_cycles = 600;
        sender_burst = 1'b1;
        for (int i = 0; i < 30; i++)
            send_rand_pixel();
        sender_burst = 1'b0;
        // sender waits for everything to drain, then continues the frame
        in_valid <= 1'b0;
        while (blurred_q.size() != 0)
            @(negedge clk);
        for (int i = 0; i < 18; i++)
            send_rand_pixel();
    endtask

    initial begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = gbrw_pkg::REG_WIDTH;
        cfg_data     = '0;
        in_valid     = 1'b0;
        action       = gbrw_pkg::ACT_PIXEL;
        weight_index = '0;
        weight_value = '0;
        in_blue      = '0;
        in_green     = '0;
        in_red       = '0;
        fail_count   = 0;
        items_sent   = 0;
        sender_burst   = 1'b0;
        receiver_burst = 1'b0;
        hold_cycles  = 0;
        pos_row      = 0;
        pos_col      = 0;
        reg_width    = 640;
        reg_height   = 480;
        reg_radius   = 1;
        foreach (line_mem[i])
            line_mem[i] = '0;
        foreach (kern[i])
            kern[i] = '0;
        foreach (win[i, j])
            win[i][j] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_backpressure();
        test_random_frames();
        settle();

        if (fail_count == 0)
            $display("** gaussian_blur_rgb_window: PASSED **");
        else
            $display("** gaussian_blur_rgb_window: FAILED **");
        $finish;
    end
endmodule
